/* design/vds_pkg.sv */
// Package with the shared constants, codes and types of the VAD decision smoother.
`default_nettype none

package vds_pkg;

	localparam int WindowMax = 64;
	localparam int IdxW = $clog2(WindowMax);
	localparam int CntW = $clog2(WindowMax + 1);
	localparam int TimerW = 17;
	localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;
	localparam int InDataW = 8;
	localparam int OutDataW = 16;

	typedef enum logic [2:0] {
		EV_NONE            = 3'd0,
		EV_WENT_ACTIVE     = 3'd1,
		EV_WENT_IDLE       = 3'd2,
		EV_SILENCE_TIMEOUT = 3'd3,
		EV_SPEECH_TIMEOUT  = 3'd4
	} event_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ACTIVE_WINDOW     = 3'd0,
		REG_ACTIVE_THRESHOLD  = 3'd1,
		REG_INACTIVE_WINDOW   = 3'd2,
		REG_INACTIVE_THRESHOLD = 3'd3,
		REG_FRAME_LENGTH      = 3'd4,
		REG_SILENCE_TIMEOUT   = 3'd5,
		REG_SPEECH_TIMEOUT    = 3'd6
	} reg_idx_t;

	localparam logic [1:0] DecVoiced = 2'b01;
	localparam logic [1:0] DecUnvoiced = 2'b00;

	typedef struct packed {
		logic            evict;
		logic [CntW-1:0] fill;
		logic [CntW-1:0] cnt;
	} push_t;

endpackage

`default_nettype wire

/* design/vad_decision_smoother_core.sv */
// Top level of the VAD decision smoother: window counting, mode switch and timers.
`default_nettype none

// Takes one raw VAD decision word per accepted input and returns exactly one
// result word for it. A new word can be accepted in every cycle unless the
// output stalls. Acceptance loads the input register, and once the result
// register is free the word passes through the window and timer update into it.
// The input stalls only while both registers hold a word and the result is not
// taken. The rate is set by the update of the window and timer state, which the
// next word reads. Configuration writes are always accepted and must only be
// issued while no word is in flight. Writing a window length restarts that
// window.
module vad_decision_smoother_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [vds_pkg::InDataW-1:0]  s_tdata,  // [1:0] vad_decision
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [vds_pkg::OutDataW-1:0]      m_tdata,  // [2:0] event_code,
	                                                    // [9:3] frames_released,
	                                                    // [10] speech_active
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [vds_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [vds_pkg::CfgDataW-1:0] cfg_data
);

	localparam int CntW = vds_pkg::CntW;
	localparam int IdxW = vds_pkg::IdxW;
	localparam int TimerW = vds_pkg::TimerW;
	localparam int WindowMax = vds_pkg::WindowMax;

	logic [6:0]  act_win_q, act_thr_q, inact_win_q, inact_thr_q;
	logic [7:0]  frame_ms_q;
	logic [15:0] sil_to_q, sp_to_q;

	logic                  active_q;
	logic [WindowMax-1:0]  on_hist_q, off_hist_q;
	logic [CntW-1:0]       on_fill_q, on_cnt_q, off_fill_q, off_cnt_q;
	logic [TimerW-1:0]     sil_ms_q, sp_ms_q;

	logic       vld_s1;
	logic [1:0] dec_s1;

	logic                 out_vld_q;
	vds_pkg::event_t      out_ev_q;
	logic [6:0]           out_rel_q;
	logic                 out_act_q;

	logic                 adv;
	logic                 step;
	logic                 voiced, unvoiced;
	logic [CntW-1:0]      on_w, off_w;
	vds_pkg::push_t       on_p, off_p;
	logic [TimerW-1:0]    sil_sum, sp_sum;
	logic                 sil_hit, sp_hit, go_active, go_idle;
	vds_pkg::event_t      ev_d;
	logic [6:0]           rel_d;
	logic                 cfg_we;

	function automatic logic [CntW-1:0] clamp_window(input logic [6:0] w);
		logic [CntW-1:0] r;
		if (w == 7'd0) begin
			r = CntW'(1);
		end else if ({1'b0, w} > 8'(WindowMax)) begin
			r = CntW'(WindowMax);
		end else begin
			r = CntW'(w);
		end
		return r;
	endfunction

	function automatic vds_pkg::push_t ring_push(input logic [WindowMax-1:0] hist,
			input logic [CntW-1:0] fill, input logic [CntW-1:0] cnt,
			input logic [CntW-1:0] w, input logic mark);
		vds_pkg::push_t r;
		logic [IdxW-1:0] idx;
		logic            dec;
		idx = IdxW'(w - CntW'(1));
		r.evict = (fill >= w);
		dec = r.evict && hist[idx] && (cnt != '0);
		r.fill = fill - CntW'(r.evict) + CntW'(1);
		r.cnt = cnt - CntW'(dec) + CntW'(mark);
		return r;
	endfunction

	function automatic logic [TimerW-1:0] timer_add(input logic [TimerW-1:0] t,
			input logic [7:0] d);
		logic [TimerW:0] s;
		s = {1'b0, t} + (TimerW + 1)'(d);
		return s[TimerW] ? vds_pkg::TimerMax : s[TimerW-1:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;

	assign adv = !out_vld_q || m_tready;
	assign s_tready = !vld_s1 || adv;
	assign step = vld_s1 && adv;

	always_comb begin
		voiced = (dec_s1 == vds_pkg::DecVoiced);
		unvoiced = (dec_s1 == vds_pkg::DecUnvoiced);
		on_w = clamp_window(act_win_q);
		off_w = clamp_window(inact_win_q);
		on_p = ring_push(on_hist_q, on_fill_q, on_cnt_q, on_w, voiced);
		off_p = ring_push(off_hist_q, off_fill_q, off_cnt_q, off_w, unvoiced);
		sil_sum = timer_add(sil_ms_q, frame_ms_q);
		sp_sum = timer_add(sp_ms_q, frame_ms_q);
		sil_hit = (sil_to_q != '0) && (sil_sum >= TimerW'(sil_to_q));
		sp_hit = (sp_to_q != '0) && (sp_sum >= TimerW'(sp_to_q));
		go_active = voiced && ({1'b0, on_p.cnt} >= (CntW + 1)'(act_thr_q));
		go_idle = unvoiced && ({1'b0, off_p.cnt} >= (CntW + 1)'(inact_thr_q));
		ev_d = vds_pkg::EV_NONE;
		rel_d = '0;
		if (!active_q) begin
			rel_d = 7'(on_p.evict);
			if (sil_hit) begin
				ev_d = vds_pkg::EV_SILENCE_TIMEOUT;
			end
			if (go_active) begin
				ev_d = vds_pkg::EV_WENT_ACTIVE;
				rel_d = 7'(on_p.evict) + 7'(on_p.fill);
			end
		end else begin
			rel_d = 7'd1;
			if (sp_hit) begin
				ev_d = vds_pkg::EV_SPEECH_TIMEOUT;
			end
			if (go_idle) begin
				ev_d = vds_pkg::EV_WENT_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_win_q <= 7'd10;
			act_thr_q <= 7'd8;
			inact_win_q <= 7'd25;
			inact_thr_q <= 7'd22;
			frame_ms_q <= 8'd20;
			sil_to_q <= '0;
			sp_to_q <= '0;
		end else if (cfg_we) begin
			case (vds_pkg::reg_idx_t'(cfg_index))
				vds_pkg::REG_ACTIVE_WINDOW: act_win_q <= cfg_data[6:0];
				vds_pkg::REG_ACTIVE_THRESHOLD: act_thr_q <= cfg_data[6:0];
				vds_pkg::REG_INACTIVE_WINDOW: inact_win_q <= cfg_data[6:0];
				vds_pkg::REG_INACTIVE_THRESHOLD: inact_thr_q <= cfg_data[6:0];
				vds_pkg::REG_FRAME_LENGTH: frame_ms_q <= cfg_data[7:0];
				vds_pkg::REG_SILENCE_TIMEOUT: sil_to_q <= cfg_data;
				vds_pkg::REG_SPEECH_TIMEOUT: sp_to_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step && !active_q) begin
			on_hist_q <= {on_hist_q[WindowMax-2:0], voiced};
		end
		if (step && active_q) begin
			off_hist_q <= {off_hist_q[WindowMax-2:0], unvoiced};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			on_fill_q <= '0;
			on_cnt_q <= '0;
			off_fill_q <= '0;
			off_cnt_q <= '0;
			sil_ms_q <= '0;
			sp_ms_q <= '0;
		end else if (step) begin
			if (!active_q) begin
				if (go_active) begin
					on_fill_q <= '0;
					on_cnt_q <= '0;
					active_q <= 1'b1;
				end else begin
					on_fill_q <= on_p.fill;
					on_cnt_q <= on_p.cnt;
				end
				sil_ms_q <= (sil_hit || (go_active && sil_to_q != '0)) ? '0 : sil_sum;
			end else begin
				if (go_idle) begin
					off_fill_q <= '0;
					off_cnt_q <= '0;
					active_q <= 1'b0;
				end else begin
					off_fill_q <= off_p.fill;
					off_cnt_q <= off_p.cnt;
				end
				sp_ms_q <= (sp_hit || (go_idle && sp_to_q != '0)) ? '0 : sp_sum;
			end
		end else if (cfg_we) begin
			if (vds_pkg::reg_idx_t'(cfg_index) == vds_pkg::REG_ACTIVE_WINDOW) begin
				on_fill_q <= '0;
				on_cnt_q <= '0;
			end
			if (vds_pkg::reg_idx_t'(cfg_index) == vds_pkg::REG_INACTIVE_WINDOW) begin
				off_fill_q <= '0;
				off_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				vld_s1 <= 1'b1;
			end else if (step) begin
				vld_s1 <= 1'b0;
			end
			if (step) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			dec_s1 <= s_tdata[1:0];
		end
		if (step) begin
			out_ev_q <= ev_d;
			out_rel_q <= rel_d;
			out_act_q <= active_q ? !go_idle : go_active;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {5'd0, out_act_q, out_rel_q, out_ev_q};

	a_on_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(on_fill_q <= CntW'(WindowMax)) && (on_cnt_q <= on_fill_q))
		else $error("onset window count or fill out of range");

	a_off_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(off_fill_q <= CntW'(WindowMax)) && (off_cnt_q <= off_fill_q))
		else $error("offset window count or fill out of range");

	a_active_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (out_ev_q == vds_pkg::EV_WENT_ACTIVE) |-> out_act_q)
		else $error("went-active word does not report active mode");

	a_idle_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (out_ev_q == vds_pkg::EV_WENT_IDLE) |-> !out_act_q)
		else $error("went-idle word reports active mode");

	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_vld_q && (out_act_q == active_q))
		else $error("processed word lost or mode mismatch");

endmodule

`default_nettype wire

/* verif/vad_decision_smoother_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the VAD decision smoother core against a predictor.
module vad_decision_smoother_core_tb;

	localparam int HoldCycles = 400;
	localparam int StallLimit = 3000;
	localparam int MaxReports = 10;
	localparam int Onset = 0;
	localparam int Offset = 1;
	localparam int WindowMax = vds_pkg::WindowMax;
	localparam int unsigned ElapsedMax = 131071;
	localparam logic [1:0] DecError = 2'b11;
	localparam logic [1:0] DecUnused = 2'b10;

	typedef struct packed {
		vds_pkg::event_t ev;
		logic [6:0]      released;
		logic            active;
	} outcome_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [vds_pkg::InDataW-1:0]  s_tdata = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [vds_pkg::OutDataW-1:0] m_tdata;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [vds_pkg::CfgIdxW-1:0]  cfg_index = '0;
	logic [vds_pkg::CfgDataW-1:0] cfg_data = '0;

	logic [1:0] decision_q[$];
	outcome_t   outcome_q[$];
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	logic       hold_go = 1'b0;
	logic       hold_done = 1'b0;
	int         mismatches = 0;
	int         results_seen = 0;
	int         stall_cycles = 0;
	int         settings_used = 1;
	int         event_tally[5] = '{default: 0};

	logic [6:0]  sm_aw, sm_athr, sm_iw, sm_ithr;
	logic [7:0]  sm_flen;
	logic [15:0] sm_sto, sm_spto;
	bit          sm_active;
	bit          win_ring[2][WindowMax];
	int unsigned win_head[2], win_fill[2], win_count[2];
	int unsigned silence_ms, speech_ms;

	vad_decision_smoother_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned clamp_len(logic [6:0] w);
		if (w == 0)
			return 1;
		if (w > WindowMax)
			return WindowMax;
		return w;
	endfunction

	function automatic void clear_window(int k);
		win_head[k] = 0;
		win_fill[k] = 0;
		win_count[k] = 0;
	endfunction

	// Returns 1 when the oldest mark had to leave the window.
	function automatic int unsigned slide_window(int k, int unsigned len, bit mark);
		int unsigned evicted = 0;
		if (win_fill[k] >= len) begin
			if (win_ring[k][win_head[k]] && win_count[k] > 0)
				win_count[k]--;
			win_head[k] = (win_head[k] + 1) % WindowMax;
			win_fill[k]--;
			evicted = 1;
		end
		win_ring[k][(win_head[k] + win_fill[k]) % WindowMax] = mark;
		win_fill[k]++;
		if (mark)
			win_count[k]++;
		return evicted;
	endfunction

	function automatic int unsigned add_ms(int unsigned t);
		return (t + sm_flen > ElapsedMax) ? ElapsedMax : t + sm_flen;
	endfunction

	function automatic void reset_smoother();
		sm_aw = 10;
		sm_athr = 8;
		sm_iw = 25;
		sm_ithr = 22;
		sm_flen = 20;
		sm_sto = 0;
		sm_spto = 0;
		sm_active = 1'b0;
		for (int i = 0; i < WindowMax; i++) begin
			win_ring[Onset][i] = 1'b0;
			win_ring[Offset][i] = 1'b0;
		end
		clear_window(Onset);
		clear_window(Offset);
		silence_ms = 0;
		speech_ms = 0;
	endfunction

	function automatic void apply_reg(vds_pkg::reg_idx_t idx,
			logic [vds_pkg::CfgDataW-1:0] v);
		case (idx)
			vds_pkg::REG_ACTIVE_WINDOW: begin
				sm_aw = v[6:0];
				clear_window(Onset);
			end
			vds_pkg::REG_ACTIVE_THRESHOLD: sm_athr = v[6:0];
			vds_pkg::REG_INACTIVE_WINDOW: begin
				sm_iw = v[6:0];
				clear_window(Offset);
			end
			vds_pkg::REG_INACTIVE_THRESHOLD: sm_ithr = v[6:0];
			vds_pkg::REG_FRAME_LENGTH: sm_flen = v[7:0];
			vds_pkg::REG_SILENCE_TIMEOUT: sm_sto = v;
			vds_pkg::REG_SPEECH_TIMEOUT: sm_spto = v;
			default: ;
		endcase
	endfunction

	function automatic void predict_frame(logic [1:0] dec);
		bit voiced = (dec == vds_pkg::DecVoiced);
		bit unvoiced = (dec == vds_pkg::DecUnvoiced);
		vds_pkg::event_t ev = vds_pkg::EV_NONE;
		int unsigned rel;
		outcome_t o;
		if (!sm_active) begin
			rel = slide_window(Onset, clamp_len(sm_aw), voiced);
			silence_ms = add_ms(silence_ms);
			if (sm_sto != 0 && silence_ms >= sm_sto) begin
				ev = vds_pkg::EV_SILENCE_TIMEOUT;
				silence_ms = 0;
			end
			if (voiced && win_count[Onset] >= sm_athr) begin
				ev = vds_pkg::EV_WENT_ACTIVE;
				rel += win_fill[Onset];
				clear_window(Onset);
				sm_active = 1'b1;
				if (sm_sto != 0)
					silence_ms = 0;
			end
		end else begin
			rel = 1;
			void'(slide_window(Offset, clamp_len(sm_iw), unvoiced));
			speech_ms = add_ms(speech_ms);
			if (sm_spto != 0 && speech_ms >= sm_spto) begin
				ev = vds_pkg::EV_SPEECH_TIMEOUT;
				speech_ms = 0;
			end
			if (unvoiced && win_count[Offset] >= sm_ithr) begin
				ev = vds_pkg::EV_WENT_IDLE;
				clear_window(Offset);
				sm_active = 1'b0;
				if (sm_spto != 0)
					speech_ms = 0;
			end
		end
		o.ev = ev;
		o.released = rel[6:0];
		o.active = sm_active;
		outcome_q.push_back(o);
	endfunction

	task automatic write_reg(vds_pkg::reg_idx_t idx, logic [vds_pkg::CfgDataW-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		apply_reg(idx, v);
	endtask

	task automatic apply_settings(logic [6:0] aw, logic [6:0] athr, logic [6:0] iw,
			logic [6:0] ithr, logic [7:0] flen, logic [15:0] sto, logic [15:0] spto);
		write_reg(vds_pkg::REG_ACTIVE_WINDOW, aw);
		write_reg(vds_pkg::REG_ACTIVE_THRESHOLD, athr);
		write_reg(vds_pkg::REG_INACTIVE_WINDOW, iw);
		write_reg(vds_pkg::REG_INACTIVE_THRESHOLD, ithr);
		write_reg(vds_pkg::REG_FRAME_LENGTH, flen);
		write_reg(vds_pkg::REG_SILENCE_TIMEOUT, sto);
		write_reg(vds_pkg::REG_SPEECH_TIMEOUT, spto);
		settings_used++;
		@(negedge clk);
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		@(posedge clk);
		send_idle_pct <= send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (decision_q.size() != 0 || s_tvalid || outcome_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Runs of one kind of decision, as talk and pauses would give, with some noise.
	task automatic queue_runs(int n, int max_run, int noise_pct);
		int pushed = 0;
		int run_len;
		logic [1:0] kind;
		while (pushed < n) begin
			if ($urandom_range(9) == 0)
				kind = DecError;
			else
				kind = ($urandom_range(1) != 0) ? vds_pkg::DecVoiced : vds_pkg::DecUnvoiced;
			run_len = $urandom_range(max_run, 1);
			for (int i = 0; i < run_len && pushed < n; i++) begin
				if ($urandom_range(99) < noise_pct)
					decision_q.push_back(2'($urandom_range(3)));
				else
					decision_q.push_back(kind);
				pushed++;
			end
		end
	endtask

	always @(posedge clk) begin : drive_decisions
		logic [1:0] dec;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_frame(s_tdata[1:0]);
			if (!s_tvalid || s_tready) begin
				if (decision_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					dec = decision_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {{(vds_pkg::InDataW - 2){1'b0}}, dec};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		outcome_t want;
		outcome_t got;
		if (arst_n) begin
			m_tready <= !(hold_go && !hold_done) && ($urandom_range(99) >= recv_idle_pct);
			if (m_tvalid && m_tready) begin
				got.ev = vds_pkg::event_t'(m_tdata[2:0]);
				got.released = m_tdata[9:3];
				got.active = m_tdata[10];
				results_seen++;
				if (m_tdata[2:0] <= 3'd4)
					event_tally[m_tdata[2:0]]++;
				if (outcome_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MaxReports)
						$display("result word %0d arrived with none expected", results_seen);
				end else begin
					want = outcome_q.pop_front();
					if (got.ev !== want.ev || got.released !== want.released
							|| got.active !== want.active) begin
						mismatches++;
						if (mismatches <= MaxReports)
							$display({"word %0d: expected event %0d released %0d",
								" active %0d, got %0d %0d %0d"},
								results_seen, want.ev, want.released, want.active,
								got.ev, got.released, got.active);
					end
				end
			end
		end
	end

	initial begin
		wait (hold_go);
		repeat (HoldCycles) @(posedge clk);
		hold_done <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
					|| (cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= StallLimit) begin
				$display("no word moved for %0d cycles", stall_cycles);
				$display("TEST FAILED");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		reset_smoother();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		set_idling(27, 71);
		@(negedge clk);

		// Reset settings: every decision code, then onset with eviction and pre-roll.
		decision_q.push_back(DecError);
		decision_q.push_back(DecUnused);
		decision_q.push_back(vds_pkg::DecUnvoiced);
		decision_q.push_back(vds_pkg::DecVoiced);
		repeat (7) decision_q.push_back(vds_pkg::DecVoiced);
		decision_q.push_back(vds_pkg::DecUnvoiced);
		decision_q.push_back(DecError);
		decision_q.push_back(DecUnused);
		decision_q.push_back(vds_pkg::DecVoiced);
		queue_runs(140, 40, 12);
		wait_idle();

		apply_settings(1, 0, 1, 0, 255, 1, 1);
		queue_runs(120, 6, 20);
		wait_idle();

		// Full windows: the onset releases a whole window plus the evicted frame.
		apply_settings(64, 64, 64, 64, 1, 65535, 65535);
		repeat (128) decision_q.push_back(vds_pkg::DecUnvoiced);
		repeat (64) decision_q.push_back(vds_pkg::DecVoiced);
		repeat (64) decision_q.push_back(vds_pkg::DecUnvoiced);
		queue_runs(40, 100, 2);
		wait_idle();

		set_idling(71, 27);
		apply_settings(0, 127, 100, 100, 1, 3, 7);
		queue_runs(60, 20, 15);
		wait_idle();

		apply_settings(5, 3, 8, 6, 0, 100, 200);
		queue_runs(150, 30, 10);
		wait_idle();

		// Stay idle long enough for the silence timer to saturate.
		apply_settings(64, 127, 1, 0, 255, 0, 0);
		queue_runs(560, 40, 10);
		wait_idle();

		// Stay active long enough for the speech timer to saturate.
		set_idling(0, 0);
		apply_settings(4, 2, 64, 127, 255, 50, 0);
		queue_runs(560, 40, 10);
		wait_idle();

		apply_settings(6, 4, 9, 6, 20, 400, 1000);
		queue_runs(100, 20, 10);
		@(posedge clk);
		hold_go <= 1'b1;
		wait_idle();
		repeat (10) @(negedge clk);

		$display("Checked %0d result words over %0d register settings, %0d errors.",
			results_seen, settings_used, mismatches);
		$display("Events: none %0d, active %0d, idle %0d, silence %0d, speech %0d.",
			event_tally[vds_pkg::EV_NONE], event_tally[vds_pkg::EV_WENT_ACTIVE],
			event_tally[vds_pkg::EV_WENT_IDLE], event_tally[vds_pkg::EV_SILENCE_TIMEOUT],
			event_tally[vds_pkg::EV_SPEECH_TIMEOUT]);
		if (mismatches == 0 && outcome_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
design/vds_pkg.sv
design/vad_decision_smoother_core.sv
verif/vad_decision_smoother_core_tb.sv
